// ----- hw/rtl/sgdm_pkg.sv -----
// Shared types, widths, register codes and fixed-point helpers for the
// SGD momentum update core. No dependencies.
package sgdm_pkg;

  localparam int WORD_BITS   = 32;
  localparam int RATE_W      = 24;
  localparam int GAIN_W      = 16;
  localparam int EPOCH_W     = 16;
  localparam int CFG_W       = 24;
  // 2^24 + (2^16-1)*(2^24-1) < 2^40
  localparam int DEN_W       = RATE_W + EPOCH_W;
  localparam int CNT_W       = $clog2(RATE_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int WIDE_W      = WORD_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;
  typedef logic [RATE_W-1:0]           rate_t;
  typedef logic [GAIN_W-1:0]           gain_t;

  localparam rate_t RATE_RESET = rate_t'(16777);
  localparam rate_t DECAY_RESET = rate_t'(16777);

  typedef enum logic [1:0] {
    REG_INITIAL_RATE  = 2'd0,
    REG_RATE_DECAY    = 2'd1,
    REG_MOMENTUM_GAIN = 2'd2,
    REG_USE_NESTEROV  = 2'd3
  } reg_index_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_EPOCH  = 1'b1
  } cmd_t;

  typedef struct packed {
    word_t param;
    word_t velocity;
    word_t grad;
    rate_t rate;
  } queue_entry_t;

  typedef struct packed {
    gain_t gain;
    logic  nesterov;
  } back_cfg_t;

  // magnitude as unsigned; the most negative value maps to 2^(W-1)
  function automatic logic [WORD_BITS-1:0] mag_of(input word_t x);
    logic [WORD_BITS-1:0] m;
    m = x[WORD_BITS-1] ? WORD_BITS'(-x) : WORD_BITS'(x);
    return m;
  endfunction

  // clamp an exact sum to the signed word range
  function automatic word_t sat_word(input wide_t x);
    word_t r;
    if ((x[WIDE_W-1:WORD_BITS-1] == '0) || (x[WIDE_W-1:WORD_BITS-1] == '1)) begin
      r = x[WORD_BITS-1:0];
    end else if (x[WIDE_W-1]) begin
      r = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sgd_momentum_update_core.sv -----
// Top level of the SGD momentum update core: configuration registers,
// front end, request queue and update pipeline. Uses sgdm_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | cmd, epoch_number, param_in, velocity_in,
//          |           |                      | grad_in
//  out     | output    | out_valid / out_stall| param_out, velocity_out
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// Update requests stream at one per cycle while neither an epoch request nor a
// stalled output holds them; each accepted request is first written to the queue.
// An epoch request holds in_stall while the shift-subtract divider produces
// one rate bit per cycle; it gives no result.
// A stalled output freezes the pipeline; the two-entry queue absorbs the
// requests that arrive meanwhile, then in_stall rises.
// rst is synchronous; in_stall is high while it is asserted.
module sgd_momentum_update_core import sgdm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [EPOCH_W-1:0] epoch_number,
  input  word_t              param_in,
  input  word_t              velocity_in,
  input  word_t              grad_in,
  output logic               out_valid,
  input  logic               out_stall,
  output word_t              param_out,
  output word_t              velocity_out,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  rate_t        initial_rate;
  rate_t        rate_decay;
  gain_t        momentum_gain;
  logic         use_nesterov;
  back_cfg_t    back_cfg;
  logic         push;
  queue_entry_t push_entry;
  logic         queue_full;
  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_rate  <= RATE_RESET;
      rate_decay    <= DECAY_RESET;
      momentum_gain <= '0;
      use_nesterov  <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_INITIAL_RATE:  initial_rate  <= cfg_data[RATE_W-1:0];
        REG_RATE_DECAY:    rate_decay    <= cfg_data[RATE_W-1:0];
        REG_MOMENTUM_GAIN: momentum_gain <= cfg_data[GAIN_W-1:0];
        REG_USE_NESTEROV:  use_nesterov  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign back_cfg = '{gain: momentum_gain, nesterov: use_nesterov};

  sgdm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .epoch_number (epoch_number),
    .param_in     (param_in),
    .velocity_in  (velocity_in),
    .grad_in      (grad_in),
    .initial_rate (initial_rate),
    .rate_decay   (rate_decay),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  sgdm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (queue_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  sgdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .cfg          (back_cfg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .param_out    (param_out),
    .velocity_out (velocity_out)
  );

endmodule

// ----- hw/rtl/sgdm_rate_unit.sv -----
// Current learning rate register and the iterative rate divider.
// Uses sgdm_pkg.
module sgdm_rate_unit import sgdm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [EPOCH_W-1:0] epoch,
  input  rate_t              initial_rate,
  input  rate_t              rate_decay,
  output rate_t              rate,
  output logic               busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } div_state_t;

  div_state_t       state;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  rate_t            quot;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             last;

  // remainder starts at initial_rate (< den), then one quotient bit per cycle
  assign trial = {rem, 1'b0};
  assign fits  = trial >= {1'b0, den};
  assign last  = cnt == CNT_W'(RATE_W - 1);
  assign busy  = state == ST_DIV;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rate  <= RATE_RESET;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_DIV;
            cnt   <= '0;
          end
        end
        ST_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (last) begin
            state <= ST_IDLE;
            rate  <= {quot[RATE_W-2:0], fits};
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      den  <= (DEN_W'(1) << RATE_W) + DEN_W'(epoch) * DEN_W'(rate_decay);
      rem  <= DEN_W'(initial_rate);
      quot <= '0;
    end else begin
      quot <= {quot[RATE_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/sgdm_front.sv -----
// Front end: input handshake, command decode, epoch rate recompute.
// Uses sgdm_pkg and sgdm_rate_unit; feeds sgdm_queue.
module sgdm_front import sgdm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [EPOCH_W-1:0] epoch_number,
  input  word_t              param_in,
  input  word_t              velocity_in,
  input  word_t              grad_in,
  input  rate_t              initial_rate,
  input  rate_t              rate_decay,
  input  logic               queue_full,
  output logic               push,
  output queue_entry_t       push_entry
);

  logic  accept;
  logic  div_busy;
  logic  epoch_start;
  rate_t rate;

  assign in_stall    = rst | div_busy | queue_full;
  assign accept      = in_valid & ~in_stall;
  assign epoch_start = accept & (cmd == CMD_EPOCH);
  assign push        = accept & (cmd == CMD_UPDATE);

  // each request carries the rate in force when it was taken
  assign push_entry = '{param: param_in, velocity: velocity_in,
                        grad: grad_in, rate: rate};

  sgdm_rate_unit u_rate (
    .clk          (clk),
    .rst          (rst),
    .start        (epoch_start),
    .epoch        (epoch_number),
    .initial_rate (initial_rate),
    .rate_decay   (rate_decay),
    .rate         (rate),
    .busy         (div_busy)
  );

endmodule

// ----- hw/rtl/sgdm_queue.sv -----
// Two-entry request queue between front and back ends.
// Uses sgdm_pkg.
module sgdm_queue import sgdm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output queue_entry_t head
);

  queue_entry_t      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/sgdm_back.sv -----
// Back end: six-stage update pipeline with the output register as last stage.
// Uses sgdm_pkg; drains sgdm_queue.
module sgdm_back import sgdm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  queue_entry_t q_head,
  output logic         q_pop,
  input  back_cfg_t    cfg,
  output logic         out_valid,
  input  logic         out_stall,
  output word_t        param_out,
  output word_t        velocity_out
);

  localparam int LRG_PW = WORD_BITS + RATE_W;
  localparam int MV_PW  = WORD_BITS + GAIN_W;
  localparam logic [LRG_PW-1:0] LRG_HALF = LRG_PW'(1) << (RATE_W - 1);
  localparam logic [MV_PW-1:0]  MV_HALF  = MV_PW'(1) << (GAIN_W - 1);

  logic adv;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;

  // stage 1: magnitude products
  logic [LRG_PW-1:0] s1_lrg_prod;
  logic [MV_PW-1:0]  s1_mv_prod;
  logic              s1_g_neg, s1_v_neg, s1_rz;
  word_t             s1_param, s1_vel;
  // stage 2: rounded, signed terms
  word_t             s2_lrg, s2_mv, s2_param, s2_vel;
  logic              s2_rz;
  // stage 3: new velocity, plain-descent parameter
  word_t             s3_nv, s3_np_plain, s3_lrg, s3_param, s3_vel;
  logic              s3_rz;
  // stage 4: look-ahead product
  logic [MV_PW-1:0]  s4_nvm_prod;
  logic              s4_nv_neg, s4_rz;
  word_t             s4_nv, s4_np_plain, s4_lrg, s4_param, s4_vel;
  // stage 5
  word_t             s5_mvn, s5_np_heavy, s5_nv, s5_np_plain, s5_lrg, s5_param, s5_vel;
  logic              s5_rz;

  logic [LRG_PW-1:0] lrg_rnd;
  logic [MV_PW-1:0]  mv_rnd, mvn_rnd;
  word_t             lrg_mag, mv_mag, mvn_mag;
  wide_t             step, np_nest;

  assign adv       = ~(s6_valid & out_stall);
  assign q_pop     = q_valid & adv;
  assign out_valid = s6_valid;

  assign lrg_rnd = s1_lrg_prod + LRG_HALF;
  assign mv_rnd  = s1_mv_prod + MV_HALF;
  assign mvn_rnd = s4_nvm_prod + MV_HALF;
  assign lrg_mag = lrg_rnd[LRG_PW-1:RATE_W];
  assign mv_mag  = mv_rnd[MV_PW-1:GAIN_W];
  assign mvn_mag = mvn_rnd[MV_PW-1:GAIN_W];

  // look-ahead step is kept exact; only the final sum saturates
  assign step    = WIDE_W'(s5_mvn) - WIDE_W'(s5_lrg);
  assign np_nest = WIDE_W'(s5_param) + step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lrg_prod <= LRG_PW'(mag_of(q_head.grad)) * LRG_PW'(q_head.rate);
      s1_mv_prod  <= MV_PW'(mag_of(q_head.velocity)) * MV_PW'(cfg.gain);
      s1_g_neg    <= q_head.grad[WORD_BITS-1];
      s1_v_neg    <= q_head.velocity[WORD_BITS-1];
      s1_rz       <= q_head.rate == '0;
      s1_param    <= q_head.param;
      s1_vel      <= q_head.velocity;

      s2_lrg   <= s1_g_neg ? -lrg_mag : lrg_mag;
      s2_mv    <= s1_v_neg ? -mv_mag : mv_mag;
      s2_rz    <= s1_rz;
      s2_param <= s1_param;
      s2_vel   <= s1_vel;

      s3_nv       <= sat_word(WIDE_W'(s2_mv) - WIDE_W'(s2_lrg));
      s3_np_plain <= sat_word(WIDE_W'(s2_param) - WIDE_W'(s2_lrg));
      s3_lrg      <= s2_lrg;
      s3_rz       <= s2_rz;
      s3_param    <= s2_param;
      s3_vel      <= s2_vel;

      s4_nvm_prod <= MV_PW'(mag_of(s3_nv)) * MV_PW'(cfg.gain);
      s4_nv_neg   <= s3_nv[WORD_BITS-1];
      s4_nv       <= s3_nv;
      s4_np_plain <= s3_np_plain;
      s4_lrg      <= s3_lrg;
      s4_rz       <= s3_rz;
      s4_param    <= s3_param;
      s4_vel      <= s3_vel;

      s5_mvn      <= s4_nv_neg ? -mvn_mag : mvn_mag;
      s5_np_heavy <= sat_word(WIDE_W'(s4_param) + WIDE_W'(s4_nv));
      s5_nv       <= s4_nv;
      s5_np_plain <= s4_np_plain;
      s5_lrg      <= s4_lrg;
      s5_rz       <= s4_rz;
      s5_param    <= s4_param;
      s5_vel      <= s4_vel;

      if (s5_rz) begin
        param_out    <= s5_param;
        velocity_out <= s5_vel;
      end else if (cfg.gain == '0) begin
        param_out    <= s5_np_plain;
        velocity_out <= s5_vel;
      end else begin
        param_out    <= cfg.nesterov ? sat_word(np_nest) : s5_np_heavy;
        velocity_out <= s5_nv;
      end
    end
  end

endmodule

// ----- hw/rtl/sgdm_checker.sv -----
// Port-level checks for sgd_momentum_update_core, bound to the top level.
// Uses sgdm_pkg.
module sgdm_checker import sgdm_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_stall,
  input logic  cmd,
  input logic  out_valid,
  input logic  out_stall,
  input word_t param_out,
  input word_t velocity_out
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(param_out) && $stable(velocity_out))
    else $error("result changed while stalled");

  // an epoch request keeps the input stalled as the divider starts
  a_epoch_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == CMD_EPOCH |=> in_stall ##1 in_stall)
    else $error("input taken during rate recompute");

  // reset empties the pipeline
  a_rst_flush: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // reset blocks the input
  a_rst_stall: assert property (@(posedge clk) rst |-> in_stall)
    else $error("input open during reset");

endmodule

bind sgd_momentum_update_core sgdm_checker u_checker (.*);
